FILE: rtl/camera_ray_generator_macros.svh
// Assertion macros used by the ray generator back pipeline.
`ifndef CAMERA_RAY_GENERATOR_MACROS_SVH
`define CAMERA_RAY_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CRG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRG_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRG_ASSERT(label, clk, rst_n, prop, msg)
`define CRG_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/crg_pkg.sv
package crg_pkg;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_M0_XY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_M0_ZW = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_M1_XY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_M1_ZW = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_M2_XY = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_M2_ZW = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH = 3'd7;

    // Depth of the front-to-back queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               degenerate;
    } ray_t;

    // Camera-space coordinates handed from front to back.
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } cam_t;

    typedef struct packed {
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] m2;
        logic signed [31:0] m3;
    } mrow_t;

    // Queue occupancy flags between queue and its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage

FILE: rtl/crg_front.sv
module crg_front #(
    parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  crg_pkg::pixel_t      in_data,
    input  logic [63:0]          half_extent,
    input  logic [30:0]          pitch,
    input  crg_pkg::qstat_t      qstat,
    output logic                 push,
    output crg_pkg::cam_t        push_data
);
    import crg_pkg::*;

    // Only the low COORD_BITS bits of a pixel index take part.
    localparam logic [11:0] PX_MASK = 12'((64'd1 << COORD_BITS) - 64'd1);

    logic [11:0]           px, py;
    logic                  valid_reg;
    cam_t                  cam_reg;
    logic                  take;

    assign px = in_data.pixel_x & PX_MASK;
    assign py = in_data.pixel_y & PX_MASK;

    // One stage register; it drains into the queue whenever the queue has room.
    assign in_stall = valid_reg && qstat.full;
    assign take     = in_valid && !in_stall;
    assign push     = valid_reg && !qstat.full;
    assign push_data = cam_reg;

    function automatic logic signed [31:0] coord(input logic signed [31:0] h,
                                                 input logic [11:0] p,
                                                 input logic [30:0] pp);
        logic signed [63:0] twice;
        logic [12:0] odd;
        logic [43:0] prod;
        odd   = {p, 1'b1};
        prod  = odd * pp;
        twice = 64'(signed'({{32{h[31]}}, h, 1'b0} >>> 0)) - 64'(prod);
        return sat32((twice + 64'sd1) >>> 1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cam_reg.cx <= coord(half_extent[63:32], px, pitch);
            cam_reg.cy <= coord(half_extent[31:0], py, pitch);
        end
    end
endmodule

FILE: rtl/crg_queue.sv
module crg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crg_pkg::cam_t   push_data,
    input  logic            pop,
    output crg_pkg::cam_t   pop_data,
    output crg_pkg::qstat_t qstat
);
    import crg_pkg::*;

    cam_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QPTR_BITS:0]   cnt_reg;

    assign qstat.full  = cnt_reg == (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign qstat.empty = cnt_reg == '0;
    assign pop_data    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end
endmodule

FILE: rtl/crg_back.sv
`include "camera_ray_generator_macros.svh"
module crg_back #(
    parameter int FRAC_BITS = crg_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  crg_pkg::qstat_t qstat,
    input  crg_pkg::cam_t   pop_data,
    output logic            pop,
    input  crg_pkg::mrow_t  row0,
    input  crg_pkg::mrow_t  row1,
    input  crg_pkg::mrow_t  row2,
    output logic            out_valid,
    input  logic            out_stall,
    output crg_pkg::ray_t   out_data
);
    import crg_pkg::*;

    // Pipeline: S1 products, S2 sums/magnitudes, S3 scale, S4 sum of squares, a 32-step
    // square root, a 47-step divider per lane (default FRAC_BITS), then an output register.
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 30 + FRAC_BITS + 1;
    localparam int NSTG      = 4 + SQ_STEPS + DIV_STEPS + 1;

    logic adv;
    logic [NSTG-1:0] v_reg;

    assign adv = !(v_reg[NSTG-1] && out_stall);
    assign pop = adv && !qstat.empty;
    assign out_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSTG-2:0], pop};
    end

    // Stage 1: products.
    logic signed [63:0] p_reg [3][2];
    logic signed [31:0] m2_1 [3];
    logic signed [31:0] org1 [3];
    mrow_t rows [3];
    assign rows[0] = row0;
    assign rows[1] = row1;
    assign rows[2] = row2;

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i][0] <= 64'(rows[i].m0) * 64'(pop_data.cx);
                p_reg[i][1] <= 64'(rows[i].m1) * 64'(pop_data.cy);
                m2_1[i] <= rows[i].m2;
                org1[i] <= rows[i].m3;
            end
    end

    // Stage 2: direction components as magnitudes and signs.
    logic [63:0] mag2 [3];
    logic        neg2 [3];
    logic signed [31:0] org2 [3];
    always_ff @(posedge clk)
    begin
        logic signed [63:0] d;
        if (adv)
            for (int i = 0; i < 3; i++)
            begin
                d = (p_reg[i][0] >>> FRAC_BITS) + (p_reg[i][1] >>> FRAC_BITS)
                    - 64'(m2_1[i]);
                neg2[i] <= d[63];
                mag2[i] <= d[63] ? 64'(-d) : 64'(d);
                org2[i] <= org1[i];
            end
    end

    // Stage 3: normalize so the largest lies in [2^29, 2^30).
    logic [63:0] mx;
    logic [6:0]  lz;
    always_comb
    begin
        mx = mag2[0] > mag2[1] ? mag2[0] : mag2[1];
        mx = mx > mag2[2] ? mx : mag2[2];
        lz = 7'd64;
        for (int b = 0; b < 64; b++)
            if (mx[b])
                lz = 7'(63 - b);
    end

    logic [29:0] mag3 [3];
    logic        neg3 [3];
    logic        deg3;
    logic signed [31:0] org3 [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg3 <= mx == '0;
            for (int i = 0; i < 3; i++)
            begin
                if (lz < 7'd34)
                    mag3[i] <= 30'(mag2[i] >> (7'd34 - lz));
                else
                    mag3[i] <= 30'(mag2[i] << (lz - 7'd34));
                neg3[i] <= neg2[i];
                org3[i] <= org2[i];
            end
        end
    end

    // Stage 4: sum of squares.
    logic [61:0] sum4;
    logic [29:0] mag4 [3];
    logic        neg4 [3];
    logic        deg4;
    logic signed [31:0] org4 [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum4 <= 62'(mag3[0] * mag3[0]) + 62'(mag3[1] * mag3[1])
                  + 62'(mag3[2] * mag3[2]);
            mag4 <= mag3;
            neg4 <= neg3;
            deg4 <= deg3;
            org4 <= org3;
        end
    end

    // Square root: one result bit per stage.
    logic [63:0] sr_n   [SQ_STEPS+1];
    logic [31:0] sr_r   [SQ_STEPS+1];
    logic [29:0] sr_m   [SQ_STEPS+1][3];
    logic        sr_ng  [SQ_STEPS+1][3];
    logic        sr_d   [SQ_STEPS+1];
    logic signed [31:0] sr_o [SQ_STEPS+1][3];

    assign sr_n[0]  = 64'(sum4);
    assign sr_r[0]  = '0;
    assign sr_m[0]  = mag4;
    assign sr_ng[0] = neg4;
    assign sr_d[0]  = deg4;
    assign sr_o[0]  = org4;

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sqrt
        localparam int K = SQ_STEPS - 1 - s;
        logic [63:0] trial;
        logic [63:0] rem_hi;
        assign trial  = ({32'd0, sr_r[s]} << (K + 1)) + (64'd1 << (2 * K));
        assign rem_hi = sr_n[s];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_hi >= trial)
                begin
                    sr_n[s+1] <= rem_hi - trial;
                    sr_r[s+1] <= sr_r[s] | (32'd1 << K);
                end
                else
                begin
                    sr_n[s+1] <= rem_hi;
                    sr_r[s+1] <= sr_r[s];
                end
                sr_m[s+1]  <= sr_m[s];
                sr_ng[s+1] <= sr_ng[s];
                sr_d[s+1]  <= sr_d[s];
                sr_o[s+1]  <= sr_o[s];
            end
        end
    end

    // Restoring divider per lane, one quotient bit per stage.
    localparam int NW = 30 + FRAC_BITS + 1;
    logic [NW-1:0] dv_n [DIV_STEPS+1][3];
    logic [NW-1:0] dv_r [DIV_STEPS+1][3];
    logic [NW-1:0] dv_q [DIV_STEPS+1][3];
    logic [31:0]   dv_l [DIV_STEPS+1];
    logic          dv_ng [DIV_STEPS+1][3];
    logic          dv_d [DIV_STEPS+1];
    logic signed [31:0] dv_o [DIV_STEPS+1][3];

    for (genvar i = 0; i < 3; i++)
    begin : g_dinit
        assign dv_n[0][i] = (NW'(sr_m[SQ_STEPS][i]) << FRAC_BITS)
                          + NW'(sr_r[SQ_STEPS] >> 1);
        assign dv_r[0][i] = '0;
        assign dv_q[0][i] = '0;
    end
    assign dv_l[0]  = sr_r[SQ_STEPS];
    assign dv_ng[0] = sr_ng[SQ_STEPS];
    assign dv_d[0]  = sr_d[SQ_STEPS];
    assign dv_o[0]  = sr_o[SQ_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        localparam int K = DIV_STEPS - 1 - s;
        always_ff @(posedge clk)
        begin
            logic [NW:0] t;
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t = {dv_r[s][i], dv_n[s][i][K]};
                    if (t >= (NW+1)'(dv_l[s]))
                    begin
                        dv_r[s+1][i] <= NW'(t - (NW+1)'(dv_l[s]));
                        dv_q[s+1][i] <= dv_q[s][i] | (NW'(1) << K);
                    end
                    else
                    begin
                        dv_r[s+1][i] <= NW'(t);
                        dv_q[s+1][i] <= dv_q[s][i];
                    end
                    dv_n[s+1][i] <= dv_n[s][i];
                end
                dv_l[s+1]  <= dv_l[s];
                dv_ng[s+1] <= dv_ng[s];
                dv_d[s+1]  <= dv_d[s];
                dv_o[s+1]  <= dv_o[s];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        logic [31:0] q [3];
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q[i] = 32'(dv_q[DIV_STEPS][i]);
                if (dv_d[DIV_STEPS])
                    q[i] = '0;
                else if (dv_ng[DIV_STEPS][i])
                    q[i] = -q[i];
            end
            out_data.origin_x   <= dv_o[DIV_STEPS][0];
            out_data.origin_y   <= dv_o[DIV_STEPS][1];
            out_data.origin_z   <= dv_o[DIV_STEPS][2];
            out_data.dir_x      <= q[0];
            out_data.dir_y      <= q[1];
            out_data.dir_z      <= q[2];
            out_data.degenerate <= dv_d[DIV_STEPS];
        end
    end

    `CRG_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !qstat.empty, "pop from empty queue")
    `CRG_ASSERT(a_hold_stall, clk, rst_n, (out_valid && out_stall) |=> $stable(out_data), "output changed under stall")
    `CRG_ASSERT(a_deg_zero, clk, rst_n, (out_valid && out_data.degenerate) |-> (out_data.dir_x == 0 && out_data.dir_y == 0 && out_data.dir_z == 0), "degenerate ray with nonzero direction")
endmodule

FILE: rtl/camera_ray_generator.sv
// Pinhole camera ray generator.
// Input channel in_valid/in_stall/in_data carries one pixel item (x, y).
// Output channel out_valid/out_stall/out_data carries one ray item per pixel:
// origin, unit direction in signed Q16.16, and a degenerate flag.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the matrix rows,
// half extents and pixel pitch; write only while the block is idle.
// Throughput: one item per clock while the output is not stalled. Latency is set
// mostly by the bit-per-stage square root (32 stages) and the bit-per-stage divider
// (47 stages at the default fraction width) in the back pipeline.
// A front stage computes camera coordinates and feeds a four-entry queue;
// the back pipeline drains it while its output is not stalled.
// When the receiver stalls, the back pipeline freezes, the queue fills and
// then the input channel stalls. Reset empties the pipeline and queue and
// loads the identity matrix, half extents of 1.0 and a pitch of 1/128.
module camera_ray_generator #(
    parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = crg_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  crg_pkg::pixel_t                   in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output crg_pkg::ray_t                     out_data,
    input  logic                              cfg_we,
    input  logic [crg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [crg_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import crg_pkg::*;

    logic [63:0] m_xy_reg [3];
    logic [63:0] m_zw_reg [3];
    logic [63:0] half_reg;
    logic [30:0] pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_xy_reg[0] <= 64'h0001_0000_0000_0000;
            m_zw_reg[0] <= '0;
            m_xy_reg[1] <= 64'h0000_0000_0001_0000;
            m_zw_reg[1] <= '0;
            m_xy_reg[2] <= '0;
            m_zw_reg[2] <= 64'h0001_0000_0000_0000;
            half_reg    <= 64'h0001_0000_0001_0000;
            pitch_reg   <= 31'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_M0_XY: m_xy_reg[0] <= cfg_data;
                REG_M0_ZW: m_zw_reg[0] <= cfg_data;
                REG_M1_XY: m_xy_reg[1] <= cfg_data;
                REG_M1_ZW: m_zw_reg[1] <= cfg_data;
                REG_M2_XY: m_xy_reg[2] <= cfg_data;
                REG_M2_ZW: m_zw_reg[2] <= cfg_data;
                REG_HALF:  half_reg    <= cfg_data;
                REG_PITCH: pitch_reg   <= cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    mrow_t rows [3];
    for (genvar i = 0; i < 3; i++)
    begin : g_rows
        assign rows[i] = {m_xy_reg[i], m_zw_reg[i]};
    end

    qstat_t qstat;
    logic   push, pop;
    cam_t   push_data, pop_data;

    crg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .half_extent(half_reg), .pitch(pitch_reg),
        .qstat, .push, .push_data
    );

    crg_queue u_queue (
        .clk, .rst_n, .push, .push_data, .pop, .pop_data, .qstat
    );

    crg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .qstat, .pop_data, .pop,
        .row0(rows[0]), .row1(rows[1]), .row2(rows[2]),
        .out_valid, .out_stall, .out_data
    );
endmodule
